// File: rtl/core/assert_macros.svh
// assertion macros, empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/wsfd_pkg.sv
package wsfd_pkg;
    localparam int LIMIT_BITS = 25;

    // configuration register indexes
    localparam logic REG_IS_SERVER = 1'b0;
    localparam logic REG_MAX_BYTES = 1'b1;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [1:0] REPLY_NONE  = 2'd0;
    localparam logic [1:0] REPLY_PONG  = 2'd1;
    localparam logic [1:0] REPLY_CLOSE = 2'd2;

    localparam logic [3:0] ERR_RSV      = 4'd0;
    localparam logic [3:0] ERR_MASK     = 4'd1;
    localparam logic [3:0] ERR_SHORT16  = 4'd2;
    localparam logic [3:0] ERR_BAD64    = 4'd3;
    localparam logic [3:0] ERR_OVER     = 4'd4;
    localparam logic [3:0] ERR_BADCTRL  = 4'd5;
    localparam logic [3:0] ERR_STRAY    = 4'd6;
    localparam logic [3:0] ERR_FRAGOVER = 4'd7;
    localparam logic [3:0] ERR_DATAFRAG = 4'd8;
    localparam logic [3:0] ERR_CLOSE1   = 4'd9;
    localparam logic [3:0] ERR_TEXT     = 4'd10;
    localparam logic [3:0] ERR_UNKNOWN  = 4'd11;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            data;
        logic [3:0]            opcode;
        logic                  fin;
        logic                  masked;
        logic [LIMIT_BITS-1:0] length;
        logic [7:0]            cons;
        logic [1:0]            reply;
        logic [3:0]            err;
    } t_result;

    // parse step output: up to two results from one byte
    typedef struct packed {
        logic    valid0;
        t_result res0;
        logic    valid1;
        t_result res1;
    } t_step;
endpackage

// File: rtl/core/wsfd_parser.sv
module wsfd_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_is_server,
    input  logic [wsfd_pkg::LIMIT_BITS-1:0] i_cfg_max,
    input  logic                            i_en,
    input  logic                            i_action,
    input  logic [7:0]                      i_byte,
    output wsfd_pkg::t_step                 o_step
);
    typedef enum logic [2:0] {
        PH_FIRST, PH_SECOND, PH_LEN16, PH_LEN64, PH_MASK, PH_PAYLOAD
    } t_phase;

    localparam int LB = wsfd_pkg::LIMIT_BITS;

    t_phase       r_phase, n_phase;
    logic [7:0]   r_h1, n_h1, r_h2, n_h2;
    logic [63:0]  r_len, n_len;
    logic [3:0]   r_cnt, n_cnt;
    logic [31:0]  r_key, n_key;
    logic [LB-1:0] r_pay, n_pay;
    logic [3:0]   r_perr, n_perr;
    logic         r_pvalid, n_pvalid;
    logic         r_infrag, n_infrag;
    logic [LB-1:0] r_ftot, n_ftot;
    logic         r_csent, n_csent;
    logic         r_closed, n_closed;
    logic         r_failed, n_failed;

    wsfd_pkg::t_step st;
    assign o_step = st;

    function automatic wsfd_pkg::t_result mk_err(input logic [3:0] c);
        wsfd_pkg::t_result r;
        r = '0;
        r.kind = wsfd_pkg::KIND_ERR;
        r.err = c;
        return r;
    endfunction

    // header size with key
    function automatic logic [7:0] hsize(input logic [7:0] h2);
        logic [7:0] s;
        s = 8'd2;
        if (h2[6:0] == 7'd126) s = s + 8'd2;
        else if (h2[6:0] == 7'd127) s = s + 8'd8;
        if (h2[7]) s = s + 8'd4;
        return s;
    endfunction

    always_comb begin
        logic [3:0] op;
        logic [63:0] len;
        logic do_len, do_start, do_finish;
        logic [LB-1:0] sum;
        logic [LB:0] maxe;
        logic [7:0] v;
        logic [1:0] reply;
        wsfd_pkg::t_result fr, pr;
        n_phase = r_phase; n_h1 = r_h1; n_h2 = r_h2; n_len = r_len; n_cnt = r_cnt;
        n_key = r_key; n_pay = r_pay; n_perr = r_perr; n_pvalid = r_pvalid;
        n_infrag = r_infrag; n_ftot = r_ftot; n_csent = r_csent;
        n_closed = r_closed; n_failed = r_failed;
        st = '0;
        op = r_h1[3:0];
        len = r_len;
        do_len = 1'b0; do_start = 1'b0; do_finish = 1'b0;
        sum = '0; maxe = '0; v = '0; reply = wsfd_pkg::REPLY_NONE;
        fr = '0; pr = '0;
        if (i_en && i_action) begin
            n_csent = 1'b1;
        end else if (i_en && !r_failed) begin
            case (r_phase)
                PH_SECOND: begin
                    n_h2 = i_byte;
                    n_len = '0;
                    n_cnt = '0;
                    if (r_h1[6:4] != 3'd0) begin
                        st.valid0 = 1'b1; st.res0 = mk_err(wsfd_pkg::ERR_RSV);
                        n_failed = 1'b1;
                    end else if (i_byte[7] != i_cfg_is_server) begin
                        st.valid0 = 1'b1; st.res0 = mk_err(wsfd_pkg::ERR_MASK);
                        n_failed = 1'b1;
                    end else if (i_byte[6:0] == 7'd126) begin
                        n_phase = PH_LEN16;
                    end else if (i_byte[6:0] == 7'd127) begin
                        n_phase = PH_LEN64;
                    end else begin
                        len = {57'd0, i_byte[6:0]};
                        n_len = len;
                        do_len = 1'b1;
                    end
                end
                PH_LEN16: begin
                    len = {48'd0, r_len[7:0], i_byte};
                    n_len = len;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd1) begin
                        if (len < 64'd126) begin
                            st.valid0 = 1'b1; st.res0 = mk_err(wsfd_pkg::ERR_SHORT16);
                            n_failed = 1'b1;
                        end else begin
                            do_len = 1'b1;
                        end
                    end
                end
                PH_LEN64: begin
                    len = {r_len[55:0], i_byte};
                    n_len = len;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        if (len[63] || len <= 64'hffff) begin
                            st.valid0 = 1'b1; st.res0 = mk_err(wsfd_pkg::ERR_BAD64);
                            n_failed = 1'b1;
                        end else begin
                            do_len = 1'b1;
                        end
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd3) do_start = 1'b1;
                end
                PH_PAYLOAD: begin
                    case (r_pay[1:0])
                        2'd0: v = i_byte ^ r_key[31:24];
                        2'd1: v = i_byte ^ r_key[23:16];
                        2'd2: v = i_byte ^ r_key[15:8];
                        default: v = i_byte ^ r_key[7:0];
                    endcase
                    pr.data = v;
                    if (!r_pvalid) begin
                        if (op == wsfd_pkg::OP_CONT || op == wsfd_pkg::OP_BIN) begin
                            st.valid0 = 1'b1; pr.kind = wsfd_pkg::KIND_DATA;
                        end else if (op == wsfd_pkg::OP_CLOSE || op == wsfd_pkg::OP_PING) begin
                            st.valid0 = 1'b1; pr.kind = wsfd_pkg::KIND_CTRL;
                        end
                    end
                    st.res0 = pr;
                    n_pay = r_pay + {{(LB-1){1'b0}}, 1'b1};
                    if ({{(64-LB){1'b0}}, n_pay} >= r_len) do_finish = 1'b1;
                end
                default: begin
                    n_h1 = i_byte;
                    n_phase = PH_SECOND;
                end
            endcase

            if (do_len) begin
                if (!op[3] && len > {{(64-LB){1'b0}}, i_cfg_max}) begin
                    st.valid0 = 1'b1; st.res0 = mk_err(wsfd_pkg::ERR_OVER);
                    n_failed = 1'b1;
                end else if (op[3] && (!r_h1[7] || len > 64'd125)) begin
                    st.valid0 = 1'b1; st.res0 = mk_err(wsfd_pkg::ERR_BADCTRL);
                    n_failed = 1'b1;
                end else if (n_h2[7]) begin
                    n_phase = PH_MASK;
                    n_cnt = '0;
                    n_key = '0;
                end else begin
                    n_key = '0;
                    do_start = 1'b1;
                end
            end

            if (do_start) begin
                n_pvalid = 1'b1;
                n_perr = '0;
                maxe = {1'b0, i_cfg_max};
                case (op)
                    wsfd_pkg::OP_CONT: begin
                        if (!r_infrag) n_perr = wsfd_pkg::ERR_STRAY;
                        else if ({1'b0, r_ftot} > maxe ||
                                 len > {{(63-LB){1'b0}}, maxe - {1'b0, r_ftot}})
                            n_perr = wsfd_pkg::ERR_FRAGOVER;
                        else n_pvalid = 1'b0;
                    end
                    wsfd_pkg::OP_BIN: begin
                        if (r_infrag) n_perr = wsfd_pkg::ERR_DATAFRAG;
                        else n_pvalid = 1'b0;
                    end
                    wsfd_pkg::OP_CLOSE: begin
                        if (len == 64'd1) n_perr = wsfd_pkg::ERR_CLOSE1;
                        else n_pvalid = 1'b0;
                    end
                    wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG: n_pvalid = 1'b0;
                    wsfd_pkg::OP_TEXT: n_perr = wsfd_pkg::ERR_TEXT;
                    default: n_perr = wsfd_pkg::ERR_UNKNOWN;
                endcase
                n_pay = '0;
                if (len == 64'd0) do_finish = 1'b1;
                else n_phase = PH_PAYLOAD;
            end

            if (do_finish) begin
                n_phase = PH_FIRST;
                if (n_pvalid) begin
                    fr = mk_err(n_perr);
                    n_failed = 1'b1;
                end else begin
                    sum = r_ftot + len[LB-1:0];
                    case (op)
                        wsfd_pkg::OP_CONT: begin
                            n_ftot = sum;
                            if (r_h1[7]) begin
                                n_infrag = 1'b0; n_ftot = '0;
                            end
                        end
                        wsfd_pkg::OP_BIN: begin
                            if (!r_h1[7]) begin
                                n_infrag = 1'b1; n_ftot = len[LB-1:0];
                            end
                        end
                        wsfd_pkg::OP_CLOSE: begin
                            n_closed = 1'b1;
                            if (!n_csent) begin
                                reply = wsfd_pkg::REPLY_CLOSE; n_csent = 1'b1;
                            end
                        end
                        wsfd_pkg::OP_PING: reply = wsfd_pkg::REPLY_PONG;
                        default: reply = wsfd_pkg::REPLY_NONE;
                    endcase
                    fr.kind = wsfd_pkg::KIND_END;
                    fr.opcode = op;
                    fr.fin = r_h1[7];
                    fr.masked = n_h2[7];
                    fr.length = len[LB-1:0];
                    fr.cons = hsize(n_h2) + (op[3] ? len[7:0] : 8'd0);
                    fr.reply = reply;
                end
                if (st.valid0) begin
                    st.valid1 = 1'b1; st.res1 = fr;
                end else begin
                    st.valid0 = 1'b1; st.res0 = fr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST; r_h1 <= '0; r_h2 <= '0; r_len <= '0; r_cnt <= '0;
            r_key <= '0; r_pay <= '0; r_perr <= '0; r_pvalid <= 1'b0;
            r_infrag <= 1'b0; r_ftot <= '0; r_csent <= 1'b0; r_closed <= 1'b0;
            r_failed <= 1'b0;
        end else begin
            r_phase <= n_phase; r_h1 <= n_h1; r_h2 <= n_h2; r_len <= n_len;
            r_cnt <= n_cnt; r_key <= n_key; r_pay <= n_pay; r_perr <= n_perr;
            r_pvalid <= n_pvalid; r_infrag <= n_infrag; r_ftot <= n_ftot;
            r_csent <= n_csent; r_closed <= n_closed; r_failed <= n_failed;
        end
    end
endmodule

// File: rtl/core/wsfd_outq.sv
module wsfd_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wsfd_pkg::t_step     i_step,
    output logic                o_ready,
    output logic                o_valid,
    output wsfd_pkg::t_result   o_res,
    output logic                o_last,
    input  logic                i_stall
);
    // 4-entry result fifo; ready needs room for two
    wsfd_pkg::t_result r_mem [4];
    logic              r_lst [4];
    logic [1:0] r_rd, r_wr;
    logic [2:0] r_cnt;
    logic pop;
    logic [1:0] nput;

    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_mem[r_rd];
    assign o_last  = r_lst[r_rd];
    assign o_ready = (r_cnt <= 3'd2);
    assign pop     = o_valid && !i_stall;
    assign nput    = i_push ? ({1'b0, i_step.valid0} + {1'b0, i_step.valid1}) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (i_push && i_step.valid0) begin
            r_mem[r_wr] <= i_step.res0;
            r_lst[r_wr] <= !i_step.valid1;
        end
        if (i_push && i_step.valid1) begin
            r_mem[r_wr + 2'd1] <= i_step.res1;
            r_lst[r_wr + 2'd1] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            r_wr <= r_wr + nput;
            if (pop) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {1'b0, nput} - {2'd0, pop};
        end
    end
endmodule

// File: rtl/core/websocket_frame_decoder.sv
// channel | direction | handshake            | payload
// in      | input     | i_valid / o_stall    | i_action, i_wire_byte
// out     | output    | o_valid / i_stall    | o_kind .. o_error_code, o_last
// cfg     | input     | i_cfg_we             | i_cfg_index, i_cfg_data
// one item per cycle while o_stall is low: the parser updates its header state in the cycle the
// item is accepted and its results land in a four-entry output queue
// results are written into the queue on acceptance, up to two per item
// o_stall rises when the queue has fewer than two free entries
// synchronous active-low reset clears parser state and queue; config resets
// to server role and 16 MiB limit
`include "assert_macros.svh"
module websocket_frame_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [wsfd_pkg::LIMIT_BITS-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_action,
    input  logic [7:0]                      i_wire_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_kind,
    output logic [7:0]                      o_data,
    output logic                            o_last,
    output logic [3:0]                      o_frame_opcode,
    output logic                            o_frame_fin,
    output logic                            o_frame_masked,
    output logic [wsfd_pkg::LIMIT_BITS-1:0] o_frame_length,
    output logic [7:0]                      o_consumable_bytes,
    output logic [1:0]                      o_reply_kind,
    output logic [3:0]                      o_error_code
);
    logic                            r_is_server;
    logic [wsfd_pkg::LIMIT_BITS-1:0] r_max;
    logic        ready;
    logic        accept;
    wsfd_pkg::t_step   step;
    wsfd_pkg::t_result res;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_server <= 1'b1;
            r_max       <= wsfd_pkg::LIMIT_BITS'(16777216);
        end else if (i_cfg_we) begin
            if (i_cfg_index == wsfd_pkg::REG_IS_SERVER) r_is_server <= i_cfg_data[0];
            else r_max <= i_cfg_data;
        end
    end

    assign o_stall = !ready;
    assign accept  = i_valid && ready;

    wsfd_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_is_server(r_is_server), .i_cfg_max(r_max),
        .i_en(accept), .i_action(i_action), .i_byte(i_wire_byte),
        .o_step(step)
    );

    wsfd_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(accept), .i_step(step),
        .o_ready(ready), .o_valid(o_valid), .o_res(res), .o_last(o_last),
        .i_stall(i_stall)
    );

    assign o_kind             = res.kind;
    assign o_data             = res.data;
    assign o_frame_opcode     = res.opcode;
    assign o_frame_fin        = res.fin;
    assign o_frame_masked     = res.masked;
    assign o_frame_length     = res.length;
    assign o_consumable_bytes = res.cons;
    assign o_reply_kind       = res.reply;
    assign o_error_code       = res.err;

    // second result only ever follows a first one
    `ASSERT_NEVER(a_slot_order, i_clk, i_rst_n, accept && step.valid1 && !step.valid0)
    // a local close never produces a result
    `ASSERT_NEVER(a_close_silent, i_clk, i_rst_n, accept && i_action && step.valid0)
    // second result is always a frame end or an error
    `ASSERT_CLK(a_second_end, i_clk, i_rst_n,
        !(accept && step.valid1) || step.res1.kind == wsfd_pkg::KIND_END ||
        step.res1.kind == wsfd_pkg::KIND_ERR)
endmodule
